>>> rtl/bdfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brace-delimited frame capture: shared definitions
// Field widths, character codes, action and status codes, register indexes.
// ----------------------------------------------------------------------------
package bdfc_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 1024;

   localparam int BYTE_W      = 8;
   localparam int ACTION_W    = 2;
   localparam int IDX_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int DEPTH_OUT_W = 11;
   localparam int LEN_OUT_W   = 11;
   localparam int SIZE_W      = 11;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FEED  = 2'd0,
      ACT_RESET = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE     = 2'd0,
      ST_PROGRESS = 2'd1,
      ST_MATCH    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIZE_IN_USE = 1'd0,
      REG_COLLAPSE    = 1'd1
   } csr_index_type;

endpackage

>>> rtl/brace_delimited_frame_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brace-delimited frame capture
// Tracks brace depth over a byte stream, stores the frame, reports status.
// ----------------------------------------------------------------------------
// channel | direction | ports                      | content
// req     | in        | req_tvalid/tready/tdata    | action, data_byte, read_index
// rsp     | out       | rsp_tvalid/tready/tdata    | status, depth, length, entered, read
// csr     | in        | csr_valid/ready/index/data | size_in_use, collapse_escaped_slash
//
// One item per cycle while results are drained; each result is registered and appears in the cycle after its transfer.
// Framer state sits in flip-flops; the buffer is a one-port-read memory whose
// registered read data lines up with the result register.
// A stalled result holds; a new item is taken whenever the result register is
// empty or being drained. Reset clears control state; buffer contents stay.
// ----------------------------------------------------------------------------
module brace_delimited_frame_capture #(
   parameter int BUFFER_DEPTH = bdfc_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] action, [9:2] data_byte, [19:10] read_index
   input  logic [bdfc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [12:2] depth, [23:13] captured_length, [24] entered,
   // [32:25] read_data
   output logic [bdfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bdfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdfc_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = $clog2(BUFFER_DEPTH + 1);
   localparam int DW = $clog2(BUFFER_DEPTH + 2) + 1;
   localparam int CW = (LW > bdfc_pkg::SIZE_W) ? LW : bdfc_pkg::SIZE_W;
   localparam logic signed [DW-1:0] DEPTH_ONE = DW'(1);
   localparam logic [CW-1:0] DEPTH_CAP = CW'(BUFFER_DEPTH);

   logic                         req_fire;
   bdfc_pkg::action_type         req_action;
   logic [bdfc_pkg::BYTE_W-1:0]  req_byte;
   logic [bdfc_pkg::IDX_W-1:0]   req_index;

   logic [bdfc_pkg::SIZE_W-1:0]  size_ff;
   logic                         collapse_ff;

   logic signed [DW-1:0]         depth_ff, depth_in;
   logic                         entered_ff, entered_in;
   logic [LW-1:0]                fill_ff, fill_in;
   logic [bdfc_pkg::BYTE_W-1:0]  last_ff, last_in;

   logic [CW-1:0]                lim;
   logic                         ovf;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [bdfc_pkg::BYTE_W-1:0]  wr_data;
   logic                         rd_en;
   logic                         rd_hit_in;
   bdfc_pkg::status_type         status_in;
   logic [DW-1:0]                depth_mag;
   logic [bdfc_pkg::BYTE_W-1:0]  mem_q;

   logic                              rsp_valid_ff;
   bdfc_pkg::status_type              status_ff;
   logic [bdfc_pkg::DEPTH_OUT_W-1:0]  depth_out_ff;
   logic [bdfc_pkg::LEN_OUT_W-1:0]    len_out_ff;
   logic                              entered_out_ff;
   logic                              rd_hit_ff;
   logic [bdfc_pkg::BYTE_W-1:0]       read_data;

   assign req_action = bdfc_pkg::action_type'(req_tdata[1:0]);
   assign req_byte   = req_tdata[9:2];
   assign req_index  = req_tdata[19:10];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= bdfc_pkg::SIZE_RESET;
         collapse_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (bdfc_pkg::csr_index_type'(csr_index))
            bdfc_pkg::REG_SIZE_IN_USE: size_ff     <= csr_data;
            bdfc_pkg::REG_COLLAPSE:    collapse_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (CW'(size_ff) > DEPTH_CAP) begin
         lim = DEPTH_CAP;
      end else if (size_ff == '0) begin
         lim = CW'(1);
      end else begin
         lim = CW'(size_ff);
      end
   end

   always_comb begin
      depth_in   = depth_ff;
      entered_in = entered_ff;
      fill_in    = fill_ff;
      last_in    = last_ff;
      ovf        = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = AW'(fill_ff);
      wr_data    = req_byte;
      rd_en      = 1'b0;
      rd_hit_in  = 1'b0;
      status_in  = bdfc_pkg::ST_IDLE;
      if (req_action == bdfc_pkg::ACT_FEED) begin
         if (req_byte == bdfc_pkg::CH_OPEN) begin
            depth_in   = depth_ff + DEPTH_ONE;
            entered_in = 1'b1;
         end
         if (entered_in) begin
            if (CW'(fill_ff) >= lim) begin
               ovf = 1'b1;
            end else begin
               if (req_byte == bdfc_pkg::CH_CLOSE) begin
                  depth_in = depth_in - DEPTH_ONE;
               end
               if (collapse_ff && (fill_ff != '0) && (last_ff == bdfc_pkg::CH_BSLASH)
                   && (req_byte == bdfc_pkg::CH_SLASH)) begin
                  wr_addr = AW'(fill_ff - 1'b1);
                  wr_data = bdfc_pkg::CH_SLASH;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
               wr_en   = 1'b1;
               last_in = req_byte;
            end
         end
         priority if (!ovf && entered_in && (depth_in == '0)) begin
            status_in = bdfc_pkg::ST_MATCH;
         end else if (ovf || (CW'(fill_in) >= lim)) begin
            depth_in   = '0;
            entered_in = 1'b0;
            fill_in    = '0;
            last_in    = '0;
            status_in  = bdfc_pkg::ST_OVERFLOW;
         end else begin
            status_in = entered_in ? bdfc_pkg::ST_PROGRESS : bdfc_pkg::ST_IDLE;
         end
      end else begin
         if (req_action == bdfc_pkg::ACT_RESET) begin
            depth_in   = '0;
            entered_in = 1'b0;
            fill_in    = '0;
            last_in    = '0;
         end
         if (req_action == bdfc_pkg::ACT_READ) begin
            rd_en     = 1'b1;
            rd_hit_in = CW'(req_index) < CW'(fill_ff);
         end
         priority if (entered_in && (depth_in == '0)) begin
            status_in = bdfc_pkg::ST_MATCH;
         end else if (entered_in) begin
            status_in = bdfc_pkg::ST_PROGRESS;
         end else begin
            status_in = bdfc_pkg::ST_IDLE;
         end
      end
   end

   assign depth_mag = depth_in[DW-1] ? DW'(-depth_in) : DW'(depth_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         entered_ff <= 1'b0;
         fill_ff    <= '0;
         last_ff    <= '0;
      end else if (req_fire) begin
         depth_ff   <= depth_in;
         entered_ff <= entered_in;
         fill_ff    <= fill_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff      <= status_in;
         depth_out_ff   <= bdfc_pkg::DEPTH_OUT_W'(depth_mag);
         len_out_ff     <= bdfc_pkg::LEN_OUT_W'(fill_in);
         entered_out_ff <= entered_in;
         rd_hit_ff      <= rd_hit_in;
      end
   end

   bdfc_capture_ram #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_capture_ram (
      .clock   (clock),
      .wr_en   (wr_en && req_fire),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en && req_fire),
      .rd_addr (AW'(req_index)),
      .rd_data (mem_q)
   );

   assign read_data = rd_hit_ff ? mem_q : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, read_data, entered_out_ff, len_out_ff, depth_out_ff, status_ff};

endmodule

>>> rtl/bdfc_capture_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture buffer memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bdfc_capture_ram #(
   parameter int DEPTH = bdfc_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bdfc_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bdfc_pkg::BYTE_W-1:0] rd_data
);

   logic [bdfc_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [bdfc_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/brace_delimited_frame_capture_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brace-delimited frame capture: self-checking test
// Drives byte, reset, read and no-op items through the request stream, and mirrors
// the framer (depth, entry, fill, escaped-slash collapse, capture store) in
// a local predictor. Every response transfer is compared field by field with
// the oldest prediction. Both streams idle at random; one phase holds the
// response side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module brace_delimited_frame_capture_test;

   localparam int CAPTURE_DEPTH = bdfc_pkg::DEFAULT_BUFFER_DEPTH;
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int FULL_SIZE     = 128;
   localparam int RANDOM_ITEMS  = 110;

   typedef struct {
      bdfc_pkg::status_type                 status;
      logic [bdfc_pkg::DEPTH_OUT_W-1:0]     depth;
      logic [bdfc_pkg::LEN_OUT_W-1:0]       length;
      logic                                 entered;
      logic [bdfc_pkg::BYTE_W-1:0]          read_data;
   } frame_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bdfc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bdfc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [bdfc_pkg::CSR_IDX_W-1:0]  csr_index  = bdfc_pkg::REG_SIZE_IN_USE;
   logic [bdfc_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   // framer mirror
   logic [bdfc_pkg::SIZE_W-1:0] size_setting;
   logic                        collapse_setting;
   int                          brace_level;
   bit                          frame_entered;
   int                          fill_count;
   logic [bdfc_pkg::BYTE_W-1:0] prev_stored;
   logic [bdfc_pkg::BYTE_W-1:0] capture_mirror [CAPTURE_DEPTH];

   frame_result_type framer_outcomes [$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   int               req_gap_max    = 14;
   int               rsp_stall_max  = 14;
   int               rsp_hold_req   = 0;

   brace_delimited_frame_capture u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int usable_size();
      int s;
      s = size_setting;
      if (s > CAPTURE_DEPTH) s = CAPTURE_DEPTH;
      if (s == 0) s = 1;
      return s;
   endfunction

   function automatic void clear_framer();
      brace_level   = 0;
      frame_entered = 0;
      fill_count    = 0;
      prev_stored   = '0;
   endfunction

   function automatic frame_result_type advance_framer(bdfc_pkg::action_type act,
                                                       logic [bdfc_pkg::BYTE_W-1:0] b,
                                                       logic [bdfc_pkg::IDX_W-1:0] idx);
      frame_result_type r;
      int               lim;
      bit               ovf;
      r.read_data = '0;
      ovf = 0;
      lim = usable_size();
      if (act == bdfc_pkg::ACT_FEED) begin
         if (b == bdfc_pkg::CH_OPEN) begin
            brace_level++;
            frame_entered = 1;
         end
         if (frame_entered) begin
            if (fill_count >= lim) begin
               ovf = 1;
            end else begin
               if (b == bdfc_pkg::CH_CLOSE) brace_level--;
               if (collapse_setting && fill_count >= 1 && prev_stored == bdfc_pkg::CH_BSLASH &&
                   b == bdfc_pkg::CH_SLASH) begin
                  capture_mirror[fill_count-1] = bdfc_pkg::CH_SLASH;
               end else begin
                  capture_mirror[fill_count] = b;
                  fill_count++;
               end
               prev_stored = b;
            end
         end
         if (!ovf && frame_entered && brace_level == 0) begin
            r.status = bdfc_pkg::ST_MATCH;
         end else if (ovf || fill_count >= lim) begin
            clear_framer();
            r.status = bdfc_pkg::ST_OVERFLOW;
         end else begin
            r.status = frame_entered ? bdfc_pkg::ST_PROGRESS : bdfc_pkg::ST_IDLE;
         end
      end else begin
         if (act == bdfc_pkg::ACT_RESET) begin
            clear_framer();
         end else if (act == bdfc_pkg::ACT_READ && int'(idx) < fill_count) begin
            r.read_data = capture_mirror[idx];
         end
         if (frame_entered && brace_level == 0) r.status = bdfc_pkg::ST_MATCH;
         else r.status = frame_entered ? bdfc_pkg::ST_PROGRESS : bdfc_pkg::ST_IDLE;
      end
      r.depth   = bdfc_pkg::DEPTH_OUT_W'((brace_level < 0) ? -brace_level : brace_level);
      r.length  = bdfc_pkg::LEN_OUT_W'(fill_count);
      r.entered = frame_entered;
      return r;
   endfunction

   task automatic send_item(input bdfc_pkg::action_type act,
                            input logic [bdfc_pkg::BYTE_W-1:0] b,
                            input logic [bdfc_pkg::IDX_W-1:0] idx);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, idx, b, act};
      do @(posedge clock); while (!req_tready);
      framer_outcomes.push_back(advance_framer(act, b, idx));
   endtask

   task automatic feed(input logic [bdfc_pkg::BYTE_W-1:0] b);
      send_item(bdfc_pkg::ACT_FEED, b,
                bdfc_pkg::IDX_W'($urandom_range(0, CAPTURE_DEPTH - 1)));
   endtask

   task automatic read_entry(input int idx);
      send_item(bdfc_pkg::ACT_READ, bdfc_pkg::BYTE_W'($urandom_range(0, 255)),
                bdfc_pkg::IDX_W'(idx));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (framer_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input bdfc_pkg::csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= bdfc_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (idx == bdfc_pkg::REG_SIZE_IN_USE) size_setting = bdfc_pkg::SIZE_W'(value);
      else collapse_setting = value[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_random_item(output bdfc_pkg::action_type act,
                                   output logic [bdfc_pkg::BYTE_W-1:0] b,
                                   output logic [bdfc_pkg::IDX_W-1:0] idx);
      int r;
      int k;
      r   = $urandom_range(0, 99);
      b   = bdfc_pkg::BYTE_W'($urandom_range(0, 255));
      idx = bdfc_pkg::IDX_W'($urandom_range(0, CAPTURE_DEPTH - 1));
      if (r < 3 || (frame_entered && brace_level == 0 && r < 50)) begin
         act = bdfc_pkg::ACT_RESET;
      end else if (r < 5) begin
         act = bdfc_pkg::ACT_NONE;
      end else if (r < 15) begin
         act = bdfc_pkg::ACT_READ;
         if (r < 12 && fill_count > 0) begin
            idx = bdfc_pkg::IDX_W'($urandom_range(0, fill_count - 1));
         end
      end else begin
         act = bdfc_pkg::ACT_FEED;
         k   = $urandom_range(0, 9);
         if (!frame_entered) begin
            if (k > 2) b = bdfc_pkg::CH_OPEN;
         end else if (brace_level > 0 && fill_count + brace_level + 1 >= usable_size()) begin
            b = bdfc_pkg::CH_CLOSE;
         end else if (k < 2) begin
            b = bdfc_pkg::CH_OPEN;
         end else if (k < 5 && brace_level > 0) begin
            b = bdfc_pkg::CH_CLOSE;
         end else if (k == 5) begin
            b = bdfc_pkg::CH_BSLASH;
         end else if (k == 6) begin
            b = bdfc_pkg::CH_SLASH;
         end
      end
   endtask

   task automatic send_random(input int count);
      bdfc_pkg::action_type        act;
      logic [bdfc_pkg::BYTE_W-1:0] b;
      logic [bdfc_pkg::IDX_W-1:0]  idx;
      repeat (count) begin
         pick_random_item(act, b, idx);
         send_item(act, b, idx);
      end
   endtask

   // fill to the configured size, close the frame in the last entry, then overflow
   task automatic test_full_buffer();
      logic [bdfc_pkg::BYTE_W-1:0] b;
      csr_write(bdfc_pkg::REG_SIZE_IN_USE, FULL_SIZE);
      feed(bdfc_pkg::CH_OPEN);
      repeat (FULL_SIZE - 2) begin
         do b = bdfc_pkg::BYTE_W'($urandom_range(0, 255));
         while (b == bdfc_pkg::CH_OPEN || b == bdfc_pkg::CH_CLOSE);
         feed(b);
      end
      feed(bdfc_pkg::CH_CLOSE);
      read_entry(FULL_SIZE - 1);
      read_entry(0);
      feed(8'h41);
      settle();
   endtask

   task automatic test_directed();
      csr_write(bdfc_pkg::REG_SIZE_IN_USE, 4);
      csr_write(bdfc_pkg::REG_COLLAPSE, 1);
      send_item(bdfc_pkg::ACT_RESET, 8'hFF, '1);
      feed(8'h00);
      feed(8'hFF);
      feed(bdfc_pkg::CH_CLOSE);
      feed(bdfc_pkg::CH_SLASH);
      feed(bdfc_pkg::CH_OPEN);
      feed(bdfc_pkg::CH_BSLASH);
      feed(bdfc_pkg::CH_SLASH);
      feed(bdfc_pkg::CH_CLOSE);
      read_entry(0);
      read_entry(1);
      read_entry(2);
      read_entry(3);
      read_entry(CAPTURE_DEPTH - 1);
      send_item(bdfc_pkg::ACT_NONE, 8'hA5, 10'h155);
      feed(bdfc_pkg::CH_CLOSE);
      feed(bdfc_pkg::CH_OPEN);
      feed(bdfc_pkg::CH_OPEN);
      feed(bdfc_pkg::CH_CLOSE);
      feed(bdfc_pkg::CH_CLOSE);
      feed(8'h41);
      settle();
      csr_write(bdfc_pkg::REG_SIZE_IN_USE, 0);
      feed(bdfc_pkg::CH_OPEN);
      settle();
      csr_write(bdfc_pkg::REG_SIZE_IN_USE, 2047);
      csr_write(bdfc_pkg::REG_COLLAPSE, 0);
      feed(bdfc_pkg::CH_OPEN);
      feed(bdfc_pkg::CH_BSLASH);
      feed(bdfc_pkg::CH_SLASH);
      read_entry(2);
      send_item(bdfc_pkg::ACT_RESET, 8'h00, '0);
      read_entry(0);
      settle();
   endtask

   task automatic test_random();
      int sizes [6] = '{2, 3, 16, CAPTURE_DEPTH, 0, 2047};
      for (int p = 0; p < 6; p++) begin
         csr_write(bdfc_pkg::REG_SIZE_IN_USE, sizes[p]);
         csr_write(bdfc_pkg::REG_COLLAPSE, p % 2);
         req_gap_max   = (p == 2) ? 0 : 14;
         rsp_stall_max = (p == 2 || p == 4) ? 0 : 14;
         send_random(RANDOM_ITEMS);
         settle();
      end
      req_gap_max   = 14;
      rsp_stall_max = 14;
   endtask

   // hold the response side while the request side offers back to back
   task automatic test_backpressure();
      csr_write(bdfc_pkg::REG_SIZE_IN_USE, 8);
      csr_write(bdfc_pkg::REG_COLLAPSE, 1);
      req_gap_max  = 0;
      rsp_hold_req = HOLD_CYCLES;
      send_random(40);
      req_gap_max  = 14;
      settle();
   endtask

   initial begin
      size_setting     = bdfc_pkg::SIZE_RESET;
      collapse_setting = 1'b0;
      clear_framer();
      for (int i = 0; i < CAPTURE_DEPTH; i++) capture_mirror[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_buffer();
      test_directed();
      test_random();
      test_backpressure();
      settle();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      frame_result_type                want;
      logic [bdfc_pkg::RSP_DATA_W-1:0] got;
      int                              stall;
      int                              hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req > 0) begin
            hold         = rsp_hold_req;
            rsp_hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = rsp_tdata;
         if (framer_outcomes.size() == 0) begin
            $error("response transfer with no item outstanding: %h", got);
            mismatch_count++;
         end else begin
            want = framer_outcomes.pop_front();
            if (got[1:0] != want.status) begin
               $error("status expected %0d actual %0d", want.status, got[1:0]);
               mismatch_count++;
            end
            if (got[12:2] != want.depth) begin
               $error("depth expected %0d actual %0d", want.depth, got[12:2]);
               mismatch_count++;
            end
            if (got[23:13] != want.length) begin
               $error("captured_length expected %0d actual %0d", want.length, got[23:13]);
               mismatch_count++;
            end
            if (got[24] != want.entered) begin
               $error("entered expected %0d actual %0d", want.entered, got[24]);
               mismatch_count++;
            end
            if (got[32:25] != want.read_data) begin
               $error("read_data expected %h actual %h", want.read_data, got[32:25]);
               mismatch_count++;
            end
         end
      end
   end

endmodule
